FILE: rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Widths, calibration register indexes and shared types for the barometric
// pressure compensation unit.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int RAW_W     = 24;
  localparam int CAL_W     = 16;
  localparam int TEMP_W    = 19;
  localparam int PRES_W    = 24;
  localparam int CFG_IDX_W = 3;
  localparam int SENS_W    = 36;
  localparam int PROD_W    = 61;

  localparam logic [CFG_IDX_W-1:0] CFG_PRES_SENS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRES_OFFS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SENS_TCO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFS_TCO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_TEMP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_TCO  = 3'd5;

  localparam logic [TEMP_W-1:0] TEMP_BASE = 19'd2000;

  typedef struct packed {
    logic pp;   // partial product stage advances
    logic sum;  // summing stage advances
  } bpc_mul_en_t;

endpackage

FILE: rtl/bpc_if.sv
// ----------------------------------------------------------------------------
// bpc_if
// Valid/ready channels: raw conversion pairs in, compensated results out.
// ----------------------------------------------------------------------------
interface bpc_in_if
  import bpc_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_pressure;
  logic [RAW_W-1:0] raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface bpc_out_if
  import bpc_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_centi;
  logic signed [PRES_W-1:0] pressure_pascal;

  modport source (output valid, output temperature_centi, output pressure_pascal,
                  input ready);
  modport sink   (input valid, input temperature_centi, input pressure_pascal,
                  output ready);
endinterface

FILE: rtl/bpc_mul.sv
// ----------------------------------------------------------------------------
// bpc_mul
// Two-stage 24 x 36 bit multiplier: sensitivity split into two 18-bit halves,
// partial products registered, then summed into a registered 61-bit product.
// ----------------------------------------------------------------------------
module bpc_mul
  import bpc_pkg::*;
(
  input  logic                     clk,
  input  bpc_mul_en_t              en,
  input  logic [RAW_W-1:0]         a,
  input  logic signed [SENS_W-1:0] b,
  output logic signed [PROD_W-1:0] prod
);

  localparam int HALF_W = SENS_W / 2;

  logic [RAW_W+HALF_W-1:0]          p_lo_r;
  logic signed [RAW_W+HALF_W:0]     p_hi_r;
  logic signed [PROD_W-1:0]         prod_r;
  logic signed [PROD_W-1:0]         prod_nxt;

  always_comb begin
    prod_nxt = $signed({p_hi_r, {HALF_W{1'b0}}})
             + $signed({{(PROD_W-RAW_W-HALF_W){1'b0}}, p_lo_r});
  end

  always_ff @(posedge clk) begin
    if (en.pp) begin
      p_lo_r <= a * b[HALF_W-1:0];
      p_hi_r <= $signed({1'b0, a}) * $signed(b[SENS_W-1:HALF_W]);
    end
    if (en.sum) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

FILE: rtl/barometric_pressure_compensation_unit.sv
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_unit
// First-order temperature compensation of raw barometer conversions.
//
// in_ch carries a raw pressure / raw temperature pair; out_ch returns the
// temperature in hundredths of a degree and the pressure in pascals, one
// result per pair, in order. The user must write the six calibration words
// through cfg_we / cfg_index / cfg_wdata only while no transfer is in
// flight; the block itself does not enforce this. Indexes above five are
// ignored. Seven register stages. One pair can be taken every cycle while
// out_ch is ready; the deepest stage is the 24 x 36 bit pressure product
// split over two stages.
// Each stage carries a valid bit and advances when it is empty or the next
// one advances, so bubbles close up while out_ch is stalled and in_ch drops
// ready only once every stage holds an item.
// Synchronous reset clears the valid bits and the calibration words.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation_unit
  import bpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  bpc_in_if.sink               in_ch,
  bpc_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CAL_W-1:0]     cfg_wdata
);

  localparam int DIFF_W = 26;
  localparam int TP_W   = DIFF_W + CAL_W + 1;
  localparam int OFFS_W = 38;
  localparam int X_W    = 40;

  logic [CAL_W-1:0] c1_r, c2_r, c3_r, c4_r, c5_r, c6_r;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, vo_r;
  logic en1, en2, en3, en4, en5, en6, en7;

  logic signed [DIFF_W-1:0] diff_r, diff_nxt;
  logic [RAW_W-1:0]         d1_s1_r, d1_s2_r, d1_s3_r;
  logic signed [TP_W-1:0]   pt_r, po_r, ps_r;

  logic signed [TP_W-1:0]   tb, ob, sb;
  logic [TEMP_W-1:0]        temp_nxt, temp_s3_r, temp_s4_r, temp_s5_r, temp_s6_r;
  logic signed [OFFS_W-1:0] offs_nxt, offs_s3_r, offs_s4_r, offs_s5_r;
  logic signed [SENS_W-1:0] sens_nxt, sens_r;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] qb;
  logic signed [X_W-1:0]    x_nxt, x_r;
  logic signed [X_W-1:0]    pb;
  logic [PRES_W-1:0]        pres_r;
  logic [TEMP_W-1:0]        temp_o_r;
  bpc_mul_en_t              mul_en;

  // calibration words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
      c4_r <= '0;
      c5_r <= '0;
      c6_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRES_SENS: c1_r <= cfg_wdata;
        CFG_PRES_OFFS: c2_r <= cfg_wdata;
        CFG_SENS_TCO:  c3_r <= cfg_wdata;
        CFG_OFFS_TCO:  c4_r <= cfg_wdata;
        CFG_REF_TEMP:  c5_r <= cfg_wdata;
        CFG_TEMP_TCO:  c6_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage advance chain
  assign en7 = !vo_r || out_ch.ready;
  assign en6 = !v6_r || en7;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ch.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ch.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
      if (en7) vo_r <= v6_r;
    end
  end

  // truncating shifts: bias negative values before the arithmetic shift
  always_comb begin
    diff_nxt = $signed({2'b00, in_ch.raw_temperature})
             - $signed({2'b00, c5_r, 8'h00});

    tb = (pt_r + (pt_r[TP_W-1] ? TP_W'((1 << 23) - 1) : TP_W'(0))) >>> 23;
    ob = (po_r + (po_r[TP_W-1] ? TP_W'(63) : TP_W'(0))) >>> 6;
    sb = (ps_r + (ps_r[TP_W-1] ? TP_W'(127) : TP_W'(0))) >>> 7;

    temp_nxt = tb[TEMP_W-1:0] + TEMP_BASE;
    offs_nxt = $signed({5'b00000, c2_r, 17'h00000}) + $signed(ob[OFFS_W-1:0]);
    sens_nxt = $signed({4'h0, c1_r, 16'h0000}) + $signed(sb[SENS_W-1:0]);

    qb    = (prod + (prod[PROD_W-1] ? PROD_W'((1 << 21) - 1) : PROD_W'(0))) >>> 21;
    x_nxt = $signed(qb[X_W-1:0]) - X_W'(offs_s5_r);
    pb    = (x_r + (x_r[X_W-1] ? X_W'((1 << 15) - 1) : X_W'(0))) >>> 15;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      diff_r  <= diff_nxt;
      d1_s1_r <= in_ch.raw_pressure;
    end
    if (en2) begin
      pt_r    <= diff_r * $signed({1'b0, c6_r});
      po_r    <= diff_r * $signed({1'b0, c4_r});
      ps_r    <= diff_r * $signed({1'b0, c3_r});
      d1_s2_r <= d1_s1_r;
    end
    if (en3) begin
      temp_s3_r <= temp_nxt;
      offs_s3_r <= offs_nxt;
      sens_r    <= sens_nxt;
      d1_s3_r   <= d1_s2_r;
    end
    if (en4) begin
      temp_s4_r <= temp_s3_r;
      offs_s4_r <= offs_s3_r;
    end
    if (en5) begin
      temp_s5_r <= temp_s4_r;
      offs_s5_r <= offs_s4_r;
    end
    if (en6) begin
      temp_s6_r <= temp_s5_r;
      x_r       <= x_nxt;
    end
    if (en7) begin
      temp_o_r <= temp_s6_r;
      pres_r   <= pb[PRES_W-1:0];
    end
  end

  assign mul_en.pp  = en4;
  assign mul_en.sum = en5;

  bpc_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (d1_s3_r),
    .b    (sens_r),
    .prod (prod)
  );

  assign out_ch.valid             = vo_r;
  assign out_ch.temperature_centi = $signed(temp_o_r);
  assign out_ch.pressure_pascal   = $signed(pres_r);

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the barometric pressure compensation unit against an integer
// predictor of the first-order compensation formula. Conversion pairs go in
// over the valid/ready input channel. The results are checked in order, field
// by field. The calibration words are rewritten between phases while the pipe
// is empty. Both ends idle at random. The receiver also holds off long enough
// for the pipe to fill, and the sender pauses until the pipe has drained.
// ----------------------------------------------------------------------------
module testbench
  import bpc_pkg::*;
();

  localparam int PIPE_DEPTH   = 7;
  localparam int HOLD_CYCLES  = 48;
  localparam int STALL_LIMIT  = 4000;
  localparam int REPORT_LIMIT = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE7 = 3'd7;

  localparam longint CENTI_BASE  = 2000;
  localparam longint REF_SCALE   = 256;
  localparam longint TEMP_DIV    = 64'sd8388608;
  localparam longint OFFS_MUL    = 64'sd131072;
  localparam longint OFFS_DIV    = 64'sd64;
  localparam longint SENS_MUL    = 64'sd65536;
  localparam longint SENS_DIV    = 64'sd128;
  localparam longint PRODUCT_DIV = 64'sd2097152;
  localparam longint PRES_DIV    = 64'sd32768;

  localparam logic [RAW_W-1:0] RAW_MAX      = '1;
  localparam logic [RAW_W-1:0] PRES_TYPICAL = 24'd6465444;
  localparam logic [CAL_W-1:0] CAL_MAX      = '1;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature_centi;
    logic signed [PRES_W-1:0] pressure_pascal;
  } comp_result_t;

  class compensation_scoreboard;
    logic [CAL_W-1:0] cal [6];
    comp_result_t     pending_results [$];
    int               mismatches;
    int               failures;

    function new();
      foreach (cal[k]) cal[k] = '0;
      mismatches = 0;
      failures   = 0;
    endfunction

    function void write_cal(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] val);
      if (idx <= CFG_TEMP_TCO) cal[idx] = val;
    endfunction

    function comp_result_t compensate(input logic [RAW_W-1:0] raw_p, input logic [RAW_W-1:0] raw_t);
      longint       diff;
      longint       temp;
      longint       offs;
      longint       sens;
      longint       pres;
      comp_result_t r;
      diff = longint'(raw_t) - longint'(cal[CFG_REF_TEMP]) * REF_SCALE;
      temp = CENTI_BASE + diff * longint'(cal[CFG_TEMP_TCO]) / TEMP_DIV;
      offs = longint'(cal[CFG_PRES_OFFS]) * OFFS_MUL
             + diff * longint'(cal[CFG_OFFS_TCO]) / OFFS_DIV;
      sens = longint'(cal[CFG_PRES_SENS]) * SENS_MUL
             + diff * longint'(cal[CFG_SENS_TCO]) / SENS_DIV;
      pres = (longint'(raw_p) * sens / PRODUCT_DIV - offs) / PRES_DIV;
      r.temperature_centi = temp[TEMP_W-1:0];
      r.pressure_pascal   = pres[PRES_W-1:0];
      return r;
    endfunction

    function void note_input(input logic [RAW_W-1:0] raw_p, input logic [RAW_W-1:0] raw_t);
      pending_results.push_back(compensate(raw_p, raw_t));
    endfunction

    function void check_result(input logic signed [TEMP_W-1:0] temp,
                               input logic signed [PRES_W-1:0] pres);
      comp_result_t want;
      if (pending_results.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: temp %0d pres %0d", temp, pres);
        return;
      end
      want = pending_results.pop_front();
      if (temp !== want.temperature_centi || pres !== want.pressure_pascal) begin
        failures++;
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch: temp %0d (expected %0d), pres %0d (expected %0d)",
                   temp, want.temperature_centi, pres, want.pressure_pascal);
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CAL_W-1:0] cfg_wdata;
  logic steady;
  logic hold_req;
  int   stall_cycles;

  compensation_scoreboard sb;

  bpc_in_if  in_if ();
  bpc_out_if out_if ();

  barometric_pressure_compensation_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // transfer monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        sb.note_input(in_if.raw_pressure, in_if.raw_temperature);
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.temperature_centi, out_if.pressure_pascal);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // receiver
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_if.ready = steady || ($urandom_range(99) >= 34);
    end
  end

  function automatic logic [RAW_W-1:0] pick_raw(input logic [RAW_W-1:0] centre);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return RAW_W'($urandom);
    if (r < 75) return centre + RAW_W'($urandom_range(2048)) - RAW_W'(1024);
    if (r < 90) return ($urandom_range(1) == 0) ? '0 : RAW_MAX;
    return RAW_W'($urandom_range(255));
  endfunction

  function automatic logic [CAL_W-1:0] rand_cal_word();
    case ($urandom_range(3))
      0:       return '0;
      1:       return CAL_MAX;
      default: return CAL_W'($urandom);
    endcase
  endfunction

  task automatic send_pair(input logic [RAW_W-1:0] p, input logic [RAW_W-1:0] t);
    while (!steady && !hold_req && $urandom_range(99) < 34) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid           = 1'b1;
    in_if.raw_pressure    = p;
    in_if.raw_temperature = t;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_cal(idx, val);
  endtask

  task automatic apply_cal(input logic [CAL_W-1:0] sens, input logic [CAL_W-1:0] offs,
                           input logic [CAL_W-1:0] sens_tco, input logic [CAL_W-1:0] offs_tco,
                           input logic [CAL_W-1:0] ref_t, input logic [CAL_W-1:0] temp_tco);
    drain();
    write_reg(CFG_PRES_SENS, sens);
    write_reg(CFG_PRES_OFFS, offs);
    write_reg(CFG_SENS_TCO, sens_tco);
    write_reg(CFG_OFFS_TCO, offs_tco);
    write_reg(CFG_REF_TEMP, ref_t);
    write_reg(CFG_TEMP_TCO, temp_tco);
  endtask

  task automatic send_random(input int n, input int steady_upto, input int hold_at,
                             input int pause_at);
    for (int k = 0; k < n; k++) begin
      steady = (k < steady_upto);
      if (k == hold_at) hold_req = 1'b1;
      if (k == pause_at) drain();
      send_pair(pick_raw(PRES_TYPICAL), pick_raw({sb.cal[CFG_REF_TEMP], 8'd0}));
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n                 = 1'b0;
    in_if.valid           = 1'b0;
    in_if.raw_pressure    = '0;
    in_if.raw_temperature = '0;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_wdata             = '0;
    steady                = 1'b0;
    hold_req              = 1'b0;
    stall_cycles          = 0;
    sb                    = new();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // calibration words at their reset value
    send_pair('0, '0);
    send_pair(RAW_MAX, RAW_MAX);
    send_pair('0, RAW_MAX);
    send_pair(RAW_MAX, '0);

    // typical part; writes to unused indexes must leave the words alone
    apply_cal(16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165);
    write_reg(CFG_IDX_SPARE6, CAL_MAX);
    write_reg(CFG_IDX_SPARE7, 16'hA5A5);
    send_pair(PRES_TYPICAL, 24'd8077636);
    send_pair(PRES_TYPICAL, 24'd8077568);
    send_pair(PRES_TYPICAL, 24'd8077567);
    send_pair(PRES_TYPICAL, 24'd8077569);
    send_pair(RAW_MAX, 24'd8077440);
    send_pair('0, '0);
    send_pair(RAW_MAX, RAW_MAX);
    send_pair(RAW_MAX, '0);
    send_pair(24'h800000, 24'h800000);

    apply_cal(CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX);
    send_pair('0, '0);
    send_pair(RAW_MAX, RAW_MAX);
    send_pair(RAW_MAX, '0);
    send_pair('0, RAW_MAX);
    send_pair(24'd1, 24'd1);
    send_random(250, 0, -1, -1);

    apply_cal(16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165);
    send_random(300, 120, 200, -1);

    apply_cal(rand_cal_word(), rand_cal_word(), rand_cal_word(),
              rand_cal_word(), rand_cal_word(), rand_cal_word());
    send_random(300, 0, -1, 150);

    repeat (3) begin
      apply_cal(rand_cal_word(), rand_cal_word(), rand_cal_word(),
                rand_cal_word(), rand_cal_word(), rand_cal_word());
      send_random(300, 0, -1, -1);
    end

    apply_cal('0, CAL_MAX, '0, CAL_MAX, '0, CAL_MAX);
    send_random(150, 0, -1, -1);
    apply_cal(CAL_MAX, '0, CAL_MAX, '0, CAL_MAX, '0);
    send_random(100, 0, -1, -1);

    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: barometric_pressure_compensation_unit.f
rtl/bpc_pkg.sv
rtl/bpc_if.sv
rtl/bpc_mul.sv
rtl/barometric_pressure_compensation_unit.sv
verif/testbench.sv
